/* sv/lwsc_pkg.sv */
// ----------------------------------------------------------------------------
// lwsc_pkg
// Shared types and constants for the LCG word stream cipher.
// ----------------------------------------------------------------------------
package lwsc_pkg;

  // Generator constants: state = state * LCG_MUL + LCG_INC (mod 2^32).
  localparam logic [31:0] LCG_MUL = 32'h41C6_4E6D;
  localparam logic [31:0] LCG_INC = 32'h0000_6073;

  // Word position counter saturates at its all-ones value.
  localparam int unsigned POS_W = 13;
  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // Header words that pass through unchanged.
  localparam logic [POS_W-1:0] HEADER_WORDS = POS_W'(4);

  // Configuration register widths and reset values.
  localparam int unsigned BLOCK_WORDS_W = 10;
  localparam int unsigned BLOCK_COUNT_W = 5;
  localparam int unsigned CFG_DATA_W = 10;
  localparam logic [BLOCK_WORDS_W-1:0] BLOCK_WORDS_RST = BLOCK_WORDS_W'(16);
  localparam logic [BLOCK_COUNT_W-1:0] BLOCK_COUNT_RST = BLOCK_COUNT_W'(4);

  // Region end: header plus block_words * block_count, wide enough for the
  // largest product plus the header.
  localparam int unsigned BLOCK_END_W = 16;

  // Configuration register indexes.
  localparam logic REG_BLOCK_WORDS = 1'b0;
  localparam logic REG_BLOCK_COUNT = 1'b1;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [15:0] word;
    logic [31:0] seed;
    logic        first;
    logic        full;
    logic        last;
  } lwsc_item_t;

  // One result beat.
  typedef struct packed {
    logic [15:0] word;
    logic        last;
  } lwsc_result_t;

endpackage

/* sv/lwsc_keystream.sv */
// ----------------------------------------------------------------------------
// lwsc_keystream
// Keystream generator state, word position tracking and the XOR of one word.
// The result is combinational; state moves forward when step is high.
// ----------------------------------------------------------------------------
module lwsc_keystream
  import lwsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     step,
  input  lwsc_item_t               item,
  input  logic [BLOCK_WORDS_W-1:0] block_words,
  input  logic [BLOCK_COUNT_W-1:0] block_count,
  output lwsc_result_t             result
);

  logic [31:0]            lcg_state;
  logic [31:0]            lcg_state_next;
  logic [31:0]            saved_seed;
  logic [POS_W-1:0]       word_position;
  logic [POS_W-1:0]       word_position_next;
  logic [BLOCK_END_W-1:0] block_end;

  logic [POS_W-1:0] pos;
  logic [31:0]      seed_src;
  logic [31:0]      state_cur;
  logic [31:0]      state_base;
  logic [31:0]      stepped;
  logic             in_region;
  logic             restart;

  // The region end is registered from the configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_end <= BLOCK_END_W'(HEADER_WORDS)
                 + BLOCK_END_W'(BLOCK_WORDS_RST) * BLOCK_END_W'(BLOCK_COUNT_RST);
    end else begin
      block_end <= BLOCK_END_W'(HEADER_WORDS)
                 + BLOCK_END_W'(block_words) * BLOCK_END_W'(block_count);
    end
  end

  // A first word starts the record at position zero with its own seed.
  always_comb begin
    pos       = item.first ? '0 : word_position;
    seed_src  = item.first ? item.seed : saved_seed;
    state_cur = item.first ? item.seed : lcg_state;
    in_region = (pos >= HEADER_WORDS);
    restart   = (pos == HEADER_WORDS)
             || ((BLOCK_END_W'(pos) == block_end) && (pos != POS_MAX));
  end

  // The generator restarts from the seed at the start of each region.
  always_comb begin
    state_base = (in_region && restart) ? seed_src : state_cur;
    stepped    = state_base * LCG_MUL + LCG_INC;
  end

  // Next state and the XORed word.
  always_comb begin
    lcg_state_next = state_cur;
    result.word    = item.word;
    result.last    = item.last;
    if (in_region) begin
      if (item.full) begin
        lcg_state_next = stepped;
        result.word    = item.word ^ stepped[31:16];
      end else begin
        lcg_state_next = state_base;
      end
    end
    word_position_next = (pos != POS_MAX) ? pos + POS_W'(1) : POS_MAX;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lcg_state     <= '0;
      saved_seed    <= '0;
      word_position <= '0;
    end else if (step) begin
      lcg_state     <= lcg_state_next;
      saved_seed    <= seed_src;
      word_position <= word_position_next;
    end
  end

endmodule

/* sv/lcg_word_stream_cipher.sv */
// Path: an accepted beat waits in the input register and is loaded into the result
// register once that register is empty or being drained; the receiver takes it there.
// Throughput: one word per cycle unless stalled; the 32-bit generator step is the loop.
// The input register and the result register are both one deep, so a stalled
// output holds one result while one more beat waits in the input register.
// Reset: synchronous; generator state, seed and position clear to zero.
// ----------------------------------------------------------------------------
// lcg_word_stream_cipher
// XORs a record of 16-bit words with an LCG keystream after a plain header,
// restarting the generator from the seed at the start and at the end of the block region.
// Reset also returns the configuration registers to 16 block words and 4 blocks.
// ----------------------------------------------------------------------------
module lcg_word_stream_cipher
  import lwsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_write,
  input  logic                  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           word_in,
  input  logic [31:0]           seed_value,
  input  logic                  first,
  input  logic                  full_word,
  input  logic                  last_in,
  // Output channel
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [15:0]           word_out,
  output logic                  last_out
);

  logic [BLOCK_WORDS_W-1:0] block_words;
  logic [BLOCK_COUNT_W-1:0] block_count;

  lwsc_item_t   in_item;
  logic         in_full;
  lwsc_result_t core_result;
  logic         advance;
  logic         in_accept;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_words <= BLOCK_WORDS_RST;
      block_count <= BLOCK_COUNT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BLOCK_WORDS: block_words <= cfg_data[BLOCK_WORDS_W-1:0];
        REG_BLOCK_COUNT: block_count <= cfg_data[BLOCK_COUNT_W-1:0];
        default:         block_words <= block_words;
      endcase
    end
  end

  // A beat moves from the input register to the result register whenever
  // the result register is empty or being drained.
  assign advance   = in_full && (!out_valid || !out_stall);
  assign in_stall  = in_full && !advance;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_accept) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_item.word  <= word_in;
      in_item.seed  <= seed_value;
      in_item.first <= first;
      in_item.full  <= full_word;
      in_item.last  <= last_in;
    end
  end

  // Keystream state and word XOR.
  lwsc_keystream u_keystream (
    .clk         (clk),
    .rst         (rst),
    .step        (advance),
    .item        (in_item),
    .block_words (block_words),
    .block_count (block_count),
    .result      (core_result)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      word_out <= core_result.word;
      last_out <= core_result.last;
    end
  end

endmodule
